// ===== rtl/frp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frp_pkg
// shared types, character codes and control structs for the fasta record parser
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam int unsigned PENDING_DEPTH_DEF = 16;

  // input command codes
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  // character codes
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;

  typedef enum logic [1:0] {
    KIND_NAME = 2'd0,
    KIND_SEQ  = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       overflow;
    logic       last;
  } out_word_t;

  // what the current input word asks of the controller
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_END  = 2'd1,
    ACT_EMIT = 2'd2
  } act_t;

  // source for the output register
  typedef enum logic [2:0] {
    OSEL_NONE = 3'd0,
    OSEL_END  = 3'd1,
    OSEL_BYTE = 3'd2,
    OSEL_RAM  = 3'd3,
    OSEL_HELD = 3'd4
  } osel_t;

  typedef struct packed {
    logic  take;
    osel_t osel;
    logic  rd_first;
    logic  rd_next;
    logic  clr_count;
  } ctrl_cmd_t;

  typedef struct packed {
    act_t act;
    logic cnt_zero;
    logic idx_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/frp_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module frp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/frp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frp_ctrl
// controller: accepts words and sequences the release of held whitespace
// ----------------------------------------------------------------------------
module frp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire frp_pkg::dp_stat_t stat,
  output frp_pkg::ctrl_cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEND,
    S_LAST
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.osel      = frp_pkg::OSEL_NONE;
    case (state_r)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.take = 1'b1;
          case (stat.act)
            frp_pkg::ACT_END: begin
              cmd.osel = frp_pkg::OSEL_END;
            end
            frp_pkg::ACT_EMIT: begin
              if (stat.cnt_zero) begin
                cmd.osel = frp_pkg::OSEL_BYTE;
              end else begin
                cmd.rd_first = 1'b1;
                state_nxt    = S_SEND;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEND: begin
        if (stat.out_free) begin
          cmd.osel = frp_pkg::OSEL_RAM;
          if (stat.idx_last) begin
            state_nxt = S_LAST;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      S_LAST: begin
        if (stat.out_free) begin
          cmd.osel      = frp_pkg::OSEL_HELD;
          cmd.clr_count = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/frp_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frp_dp
// datapath: line parser state, pending whitespace buffer and output register
// ----------------------------------------------------------------------------
module frp_dp #(
  parameter int unsigned PENDING_DEPTH = frp_pkg::PENDING_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire frp_pkg::in_word_t  in_data,
  input  wire logic               out_ready,
  input  wire frp_pkg::ctrl_cmd_t cmd,
  output frp_pkg::dp_stat_t       stat,
  output logic                    out_valid,
  output frp_pkg::out_word_t      out_data
);

  localparam int unsigned AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(PENDING_DEPTH);

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_NAME,
    MODE_HDR_REST,
    MODE_SEQ
  } mode_t;

  logic               line_start_r, line_start_nxt, dec_line_start;
  logic               rec_open_r, rec_open_nxt, dec_rec_open;
  mode_t              mode_r, mode_nxt, dec_mode;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               ovf_seen_r, ovf_seen_nxt, dec_ovf_seen;
  logic               dec_clr_cnt;
  logic               dec_hold;
  frp_pkg::act_t      dec_act;
  frp_pkg::kind_t     dec_kind;
  logic               buf_full;
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [7:0]         ram_rdata;
  logic [AW-1:0]      idx_r;
  logic [7:0]         held_byte_r;
  frp_pkg::kind_t     held_kind_r;
  logic               out_valid_r, out_valid_nxt;
  frp_pkg::out_word_t out_data_r;
  logic [7:0]         b;
  logic               is_eos;

  assign b        = in_data.data_byte;
  assign is_eos   = (in_data.cmd == frp_pkg::CMD_EOS);
  assign buf_full = (cnt_r == CNT_FULL);

  // decode of the word on the input port against the current parse state
  always_comb begin
    dec_line_start = line_start_r;
    dec_rec_open   = rec_open_r;
    dec_mode       = mode_r;
    dec_ovf_seen   = ovf_seen_r;
    dec_clr_cnt    = 1'b0;
    dec_hold       = 1'b0;
    dec_act        = frp_pkg::ACT_NONE;
    dec_kind       = frp_pkg::KIND_NAME;
    if (is_eos) begin
      if (rec_open_r) begin
        dec_act = frp_pkg::ACT_END;
      end
      dec_line_start = 1'b1;
      dec_rec_open   = 1'b0;
      dec_mode       = MODE_NONE;
      dec_clr_cnt    = 1'b1;
      dec_ovf_seen   = 1'b0;
    end else if (b == frp_pkg::CH_LF) begin
      dec_clr_cnt    = 1'b1;
      dec_line_start = 1'b1;
      if (mode_r inside {MODE_NAME, MODE_HDR_REST}) begin
        dec_mode = MODE_SEQ;
      end
    end else if (line_start_r && b == frp_pkg::CH_GT) begin
      dec_line_start = 1'b0;
      if (rec_open_r) begin
        dec_act = frp_pkg::ACT_END;
      end
      dec_ovf_seen = 1'b0;
      dec_rec_open = 1'b1;
      dec_mode     = MODE_NAME;
      dec_clr_cnt  = 1'b1;
    end else begin
      dec_line_start = 1'b0;
      case (mode_r)
        MODE_NAME: begin
          if (b inside {frp_pkg::CH_SP, frp_pkg::CH_TAB, frp_pkg::CH_CR}) begin
            dec_clr_cnt = 1'b1;
            dec_mode    = MODE_HDR_REST;
          end else if (b inside {frp_pkg::CH_VT, frp_pkg::CH_FF}) begin
            dec_hold = 1'b1;
          end else begin
            dec_act  = frp_pkg::ACT_EMIT;
            dec_kind = frp_pkg::KIND_NAME;
          end
        end
        MODE_SEQ: begin
          if (b inside {frp_pkg::CH_SP, frp_pkg::CH_CR}) begin
            dec_act = frp_pkg::ACT_NONE;
          end else if (b inside {frp_pkg::CH_TAB, frp_pkg::CH_VT, frp_pkg::CH_FF}) begin
            dec_hold = 1'b1;
          end else begin
            dec_act  = frp_pkg::ACT_EMIT;
            dec_kind = frp_pkg::KIND_SEQ;
          end
        end
        default: ;
      endcase
      if (dec_hold && buf_full) begin
        dec_ovf_seen = 1'b1;
      end
    end
  end

  assign ram_we = cmd.take && dec_hold && !buf_full;

  always_comb begin
    line_start_nxt = line_start_r;
    rec_open_nxt   = rec_open_r;
    mode_nxt       = mode_r;
    ovf_seen_nxt   = ovf_seen_r;
    cnt_nxt        = cnt_r;
    if (cmd.take) begin
      line_start_nxt = dec_line_start;
      rec_open_nxt   = dec_rec_open;
      mode_nxt       = dec_mode;
      ovf_seen_nxt   = dec_ovf_seen;
      if (dec_clr_cnt) begin
        cnt_nxt = '0;
      end else if (ram_we) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
    if (cmd.clr_count) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_start_r <= 1'b1;
      rec_open_r   <= 1'b0;
      mode_r       <= MODE_NONE;
      ovf_seen_r   <= 1'b0;
      cnt_r        <= '0;
    end else begin
      line_start_r <= line_start_nxt;
      rec_open_r   <= rec_open_nxt;
      mode_r       <= mode_nxt;
      ovf_seen_r   <= ovf_seen_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // pending whitespace buffer
  assign ram_re    = cmd.rd_first || cmd.rd_next;
  assign ram_raddr = cmd.rd_first ? '0 : (idx_r + AW'(1));

  frp_ram #(
    .WIDTH (8),
    .DEPTH (PENDING_DEPTH)
  ) u_pend_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (b),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      idx_r       <= '0;
      held_byte_r <= b;
      held_kind_r <= dec_kind;
    end else if (cmd.rd_next) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.osel != frp_pkg::OSEL_NONE) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.osel)
      frp_pkg::OSEL_END: begin
        out_data_r.kind     <= frp_pkg::KIND_END;
        out_data_r.out_byte <= '0;
        out_data_r.overflow <= ovf_seen_r;
        out_data_r.last     <= 1'b1;
      end
      frp_pkg::OSEL_BYTE: begin
        out_data_r.kind     <= dec_kind;
        out_data_r.out_byte <= b;
        out_data_r.overflow <= 1'b0;
        out_data_r.last     <= 1'b1;
      end
      frp_pkg::OSEL_RAM: begin
        out_data_r.kind     <= held_kind_r;
        out_data_r.out_byte <= ram_rdata;
        out_data_r.overflow <= 1'b0;
        out_data_r.last     <= 1'b0;
      end
      frp_pkg::OSEL_HELD: begin
        out_data_r.kind     <= held_kind_r;
        out_data_r.out_byte <= held_byte_r;
        out_data_r.overflow <= 1'b0;
        out_data_r.last     <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.act      = dec_act;
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.idx_last = ((CW'(idx_r) + CW'(1)) == cnt_r);
  assign stat.out_free = !out_valid_r || out_ready;

endmodule
`default_nettype wire

// ===== rtl/fasta_record_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fasta_record_parser
// streaming fasta parser that turns text bytes into name, sequence and
// record end words
// ----------------------------------------------------------------------------
// one input word is a text byte or an end of stream command. a word that
// produces at most one result leaves the block ready for the next word, so
// with out_ready held high the block runs at one byte per cycle. a byte that
// releases n held whitespace bytes (vt, ff, and tab on sequence lines, each
// waiting for a following kept byte) occupies the block until all are out:
// the held bytes come out of the single read port of the pending buffer one
// per cycle while out_ready is high, then the byte itself follows. results
// sit in a single output register, and a new word is taken only while that
// register is empty or is being read in the same cycle, so a result waiting for out_ready holds off the input.
module fasta_record_parser #(
  parameter int unsigned PENDING_DEPTH = frp_pkg::PENDING_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire frp_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output frp_pkg::out_word_t      out_data
);

  frp_pkg::ctrl_cmd_t cmd;
  frp_pkg::dp_stat_t  stat;

  frp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  frp_dp #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_no_take_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.osel == frp_pkg::OSEL_RAM || cmd.osel == frp_pkg::OSEL_HELD) |-> !in_ready)
    else $error("input taken while held bytes are released");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.osel != frp_pkg::OSEL_NONE) |-> stat.out_free)
    else $error("output register overwritten while full");

  a_end_word_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == frp_pkg::KIND_END) |->
      (out_data.last && out_data.out_byte == 8'h00))
    else $error("record end word malformed");

  a_ram_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.osel == frp_pkg::OSEL_RAM) |=> (out_valid && !out_data.last))
    else $error("held byte flagged as last");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_next |-> !stat.idx_last)
    else $error("pending buffer read past fill count");
`endif

endmodule
`default_nettype wire
